// File: sv/seat_pkg.sv
// Shared types, codes and the retire helper for the stream epoch admission tracker.
`default_nettype none

package seat_pkg;

   localparam int EPOCH_W   = 64;
   localparam int COUNT_W   = 32;
   localparam int OP_W      = 2;
   localparam int OBS_W     = 3;
   localparam int RSP_BITS  = OBS_W + 1 + 1 + EPOCH_W + 1 + EPOCH_W + 1 + EPOCH_W + COUNT_W;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_OBSERVE = 2'd0,
      OP_COMMIT  = 2'd1,
      OP_REJECT  = 2'd2,
      OP_CLEAR   = 2'd3
   } seat_op_type;

   typedef enum logic [OBS_W-1:0] {
      OBS_NONE      = 3'd0,
      OBS_INVALID   = 3'd1,
      OBS_ACTIVE    = 3'd2,
      OBS_RETIRED   = 3'd3,
      OBS_CANDIDATE = 3'd4,
      OBS_REPLACED  = 3'd5
   } seat_obs_type;

   typedef struct packed {
      logic                 active_flag;
      logic [EPOCH_W-1:0]   active_number;
      logic                 candidate_flag;
      logic [EPOCH_W-1:0]   candidate_number;
      logic                 retired_flag;
      logic [EPOCH_W-1:0]   retired_number;
      logic [COUNT_W-1:0]   advances;
   } seat_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   retire_advances;
      logic [EPOCH_W-1:0]   retired_mark;
      logic                 retired_present;
      logic [EPOCH_W-1:0]   candidate_value;
      logic                 candidate_present;
      logic [EPOCH_W-1:0]   active_value;
      logic                 active_present;
      logic                 commit_accepted;
      seat_obs_type         observation;
   } seat_result_type;

   // Raise the retired-through mark to e when e is valid and above it.
   function automatic seat_state_type seat_retire(seat_state_type s, logic [EPOCH_W-1:0] e);
      seat_state_type r;
      r = s;
      if ((e != '0) && (!s.retired_flag || (e > s.retired_number))) begin
         r.retired_flag   = 1'b1;
         r.retired_number = e;
         if (s.advances != '1) begin
            r.advances = s.advances + COUNT_W'(1);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/seat_engine.sv
// Epoch tracking state and its combinational update for one item.
`default_nettype none

module seat_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire seat_pkg::seat_op_type      op,
   input  wire logic [seat_pkg::EPOCH_W-1:0] epoch,
   output seat_pkg::seat_result_type       result
);
   import seat_pkg::*;

   seat_state_type state_ff;
   seat_state_type state_in;
   seat_state_type work;
   seat_obs_type   obs;
   logic           accepted;
   logic           below_mark;

   always_comb begin
      work       = state_ff;
      obs        = OBS_NONE;
      accepted   = 1'b0;
      below_mark = state_ff.retired_flag && (epoch <= state_ff.retired_number);
      case (op)
         OP_OBSERVE: begin
            if (epoch == '0) begin
               obs = OBS_INVALID;
            end else if (state_ff.active_flag && (state_ff.active_number == epoch)) begin
               obs = OBS_ACTIVE;
            end else if (below_mark) begin
               obs = OBS_RETIRED;
            end else if (state_ff.candidate_flag) begin
               if (state_ff.candidate_number == epoch) begin
                  obs = OBS_CANDIDATE;
               end else if (epoch < state_ff.candidate_number) begin
                  obs = OBS_RETIRED;
               end else begin
                  work = seat_retire(state_ff, state_ff.candidate_number);
                  work.candidate_number = epoch;
                  obs = OBS_REPLACED;
               end
            end else if (state_ff.active_flag && (epoch < state_ff.active_number)) begin
               obs = OBS_RETIRED;
            end else begin
               if (!state_ff.active_flag && (epoch > EPOCH_ONE)) begin
                  work = seat_retire(state_ff, epoch - EPOCH_ONE);
               end
               work.candidate_flag   = 1'b1;
               work.candidate_number = epoch;
               obs = OBS_CANDIDATE;
            end
         end
         OP_COMMIT: begin
            if (state_ff.candidate_flag && (state_ff.candidate_number == epoch) && !below_mark
                && !(state_ff.active_flag && (epoch <= state_ff.active_number))) begin
               if (state_ff.active_flag) begin
                  work = seat_retire(state_ff, state_ff.active_number);
               end
               work.active_flag      = 1'b1;
               work.active_number    = epoch;
               work.candidate_flag   = 1'b0;
               work.candidate_number = '0;
               accepted = 1'b1;
            end
         end
         OP_REJECT: begin
            if (state_ff.candidate_flag && (state_ff.candidate_number == epoch)) begin
               work = seat_retire(state_ff, epoch);
               work.candidate_flag   = 1'b0;
               work.candidate_number = '0;
            end
         end
         OP_CLEAR: begin
            work = '0;
         end
         default: begin
            work = state_ff;
         end
      endcase
      state_in = work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Report values after the step; absent values read as zero.
   always_comb begin
      result.observation       = obs;
      result.commit_accepted   = accepted;
      result.active_present    = work.active_flag;
      result.active_value      = work.active_flag ? work.active_number : '0;
      result.candidate_present = work.candidate_flag;
      result.candidate_value   = work.candidate_flag ? work.candidate_number : '0;
      result.retired_present   = work.retired_flag;
      result.retired_mark      = work.retired_flag ? work.retired_number : '0;
      result.retire_advances   = work.advances;
   end

endmodule

`default_nettype wire

// File: sv/stream_epoch_admission_tracker.sv
// Top level of the stream epoch admission tracker: stream ports, input and result registers.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser opcode, tdata epoch
// rsp_      out        rsp_tvalid/rsp_tready  tdata result fields (see port comment)
//
// One item per cycle sustained while rsp_tready stays high; each item is held first in the
// input register and then in the result register.
// The state update and result come from one pass of compare logic on the held item.
// Reset clears the tracker state and both valid flags; payload registers are not reset.
// A stall on rsp_ holds the result; the input register still takes one more item.

module stream_epoch_admission_tracker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [seat_pkg::EPOCH_W-1:0]  req_tdata,   // [63:0] epoch
   input  wire logic [seat_pkg::OP_W-1:0]     req_tuser,   // [1:0] opcode
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [2:0] observation, [3] commit_accepted, [4] active_present,
   // [68:5] active_value, [69] candidate_present, [133:70] candidate_value,
   // [134] retired_present, [198:135] retired_mark, [230:199] retire_advances,
   // [231] zero
   output      logic [seat_pkg::RSP_W-1:0]    rsp_tdata
);
   import seat_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   seat_op_type        in_op_ff;
   logic [EPOCH_W-1:0] in_epoch_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [RSP_W-1:0]   out_data_ff;
   logic               advance;
   logic               fire;
   logic               take;
   seat_result_type    result;

   // The result register can take a new item when empty or being drained.
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   seat_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .op     (in_op_ff),
      .epoch  (in_epoch_ff),
      .result (result)
   );

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: load the input item on accept, the result when a held item fires.
   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff    <= seat_op_type'(req_tuser);
         in_epoch_ff <= req_tdata;
      end
      if (fire) begin
         out_data_ff <= RSP_W'(result);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the stream epoch admission tracker.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import seat_pkg::*;

   localparam int RX_HOLD_CYCLES = 300;
   localparam int MAX_PRINTED    = 40;

   // Epoch book kept beside the block: what it should hold after each item
   typedef struct packed {
      bit                 has_active;
      bit [EPOCH_W-1:0]   active_ep;
      bit                 has_cand;
      bit [EPOCH_W-1:0]   cand_ep;
      bit                 has_mark;
      bit [EPOCH_W-1:0]   mark_ep;
      bit [COUNT_W-1:0]   advances;
   } epoch_book_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid;
   logic                req_tready;
   logic [EPOCH_W-1:0]  req_tdata;   // [63:0] epoch
   logic [OP_W-1:0]     req_tuser;   // [1:0] opcode
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [2:0] observation, [3] commit_accepted, [4] active_present, [68:5] active_value,
   // [69] candidate_present, [133:70] candidate_value, [134] retired_present,
   // [198:135] retired_mark, [230:199] retire_advances, [231] zero
   logic [RSP_W-1:0]    rsp_tdata;

   epoch_book_type      book;
   seat_result_type     pending_results[$];
   int                  items_sent     = 0;
   int                  results_seen   = 0;
   int                  error_count    = 0;
   int                  burst_left     = 0;
   int                  hold_off_left  = 0;

   stream_epoch_admission_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- epoch book

   // Raise the retired-through mark; zero never counts as an epoch
   function automatic void raise_mark(bit [EPOCH_W-1:0] e);
      if ((e != '0) && (!book.has_mark || (e > book.mark_ep))) begin
         book.has_mark = 1'b1;
         book.mark_ep  = e;
         if (book.advances != '1) begin
            book.advances = book.advances + COUNT_W'(1);
         end
      end
   endfunction

   function automatic seat_obs_type classify_epoch(bit [EPOCH_W-1:0] e);
      if (e == '0) return OBS_INVALID;
      if (book.has_active && (book.active_ep == e)) return OBS_ACTIVE;
      if (book.has_mark && (e <= book.mark_ep)) return OBS_RETIRED;
      if (book.has_cand) begin
         if (e == book.cand_ep) return OBS_CANDIDATE;
         if (e < book.cand_ep) return OBS_RETIRED;
         // a newer epoch displaces the waiting candidate, which is retired
         raise_mark(book.cand_ep);
         book.cand_ep = e;
         return OBS_REPLACED;
      end
      if (book.has_active && (e < book.active_ep)) return OBS_RETIRED;
      // first sight with nothing active: everything older is retired
      if (!book.has_active && (e > EPOCH_W'(1))) raise_mark(e - EPOCH_W'(1));
      book.has_cand = 1'b1;
      book.cand_ep  = e;
      return OBS_CANDIDATE;
   endfunction

   function automatic bit promote_candidate(bit [EPOCH_W-1:0] e);
      if (!book.has_cand || (book.cand_ep != e) || (book.has_mark && (e <= book.mark_ep)) ||
          (book.has_active && (e <= book.active_ep))) begin
         return 1'b0;
      end
      if (book.has_active) raise_mark(book.active_ep);
      book.has_active = 1'b1;
      book.active_ep  = e;
      book.has_cand   = 1'b0;
      book.cand_ep    = '0;
      return 1'b1;
   endfunction

   function automatic seat_result_type track_epoch(seat_op_type op, bit [EPOCH_W-1:0] e);
      seat_result_type r;
      r = '0;
      case (op)
         OP_OBSERVE: begin
            r.observation = classify_epoch(e);
         end
         OP_COMMIT: begin
            r.commit_accepted = promote_candidate(e);
         end
         OP_REJECT: begin
            if (book.has_cand && (book.cand_ep == e)) begin
               raise_mark(e);
               book.has_cand = 1'b0;
               book.cand_ep  = '0;
            end
         end
         default: begin
            book = '0;
         end
      endcase
      r.active_present    = book.has_active;
      r.active_value      = book.has_active ? book.active_ep : '0;
      r.candidate_present = book.has_cand;
      r.candidate_value   = book.has_cand ? book.cand_ep : '0;
      r.retired_present   = book.has_mark;
      r.retired_mark      = book.has_mark ? book.mark_ep : '0;
      r.retire_advances   = book.advances;
      return r;
   endfunction

   // Highest epoch the block knows of; most fresh epochs are taken above it
   function automatic bit [EPOCH_W-1:0] epoch_frontier();
      bit [EPOCH_W-1:0] f;
      f = book.mark_ep;
      if (book.has_active && (book.active_ep > f)) f = book.active_ep;
      if (book.has_cand && (book.cand_ep > f)) f = book.cand_ep;
      return f;
   endfunction

   function automatic bit [EPOCH_W-1:0] random_epoch();
      return {$urandom(), $urandom()};
   endfunction

   function automatic bit [EPOCH_W-1:0] fresh_epoch();
      case ($urandom_range(0, 15))
         0:       return random_epoch();
         1:       return '1 - $urandom_range(0, 3);
         2, 3:    return epoch_frontier() + $urandom_range(1, 1 << 20);
         default: return epoch_frontier() + $urandom_range(1, 3);
      endcase
   endfunction

   // Epochs near whatever the block holds, so that every branch is hit
   function automatic bit [EPOCH_W-1:0] nearby_epoch();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return book.cand_ep;
         2:       return book.active_ep;
         3:       return book.mark_ep - $urandom_range(0, 2);
         4:       return book.cand_ep + $urandom_range(0, 2) - 1;
         5:       return book.active_ep + $urandom_range(0, 2) - 1;
         6:       return random_epoch();
         7:       return '1 - $urandom_range(0, 2);
         default: return fresh_epoch();
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [EPOCH_W-1:0] got,
                                  logic [EPOCH_W-1:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("%0t: result %0d, %s: got %h, expected %h",
                  $realtime, results_seen, what, got, want);
      end
   endtask

   task automatic check_result(logic [RSP_W-1:0] word);
      seat_result_type got;
      seat_result_type want;
      got = word[RSP_BITS-1:0];
      if (pending_results.size() == 0) begin
         report_mismatch("result with none outstanding", '0, '0);
         return;
      end
      want = pending_results.pop_front();
      if (got.observation !== want.observation)
         report_mismatch("observation", EPOCH_W'(got.observation), EPOCH_W'(want.observation));
      if (got.commit_accepted !== want.commit_accepted)
         report_mismatch("commit_accepted", EPOCH_W'(got.commit_accepted),
                         EPOCH_W'(want.commit_accepted));
      if (got.active_present !== want.active_present)
         report_mismatch("active_present", EPOCH_W'(got.active_present),
                         EPOCH_W'(want.active_present));
      if (got.active_value !== want.active_value)
         report_mismatch("active_value", got.active_value, want.active_value);
      if (got.candidate_present !== want.candidate_present)
         report_mismatch("candidate_present", EPOCH_W'(got.candidate_present),
                         EPOCH_W'(want.candidate_present));
      if (got.candidate_value !== want.candidate_value)
         report_mismatch("candidate_value", got.candidate_value, want.candidate_value);
      if (got.retired_present !== want.retired_present)
         report_mismatch("retired_present", EPOCH_W'(got.retired_present),
                         EPOCH_W'(want.retired_present));
      if (got.retired_mark !== want.retired_mark)
         report_mismatch("retired_mark", got.retired_mark, want.retired_mark);
      if (got.retire_advances !== want.retire_advances)
         report_mismatch("retire_advances", EPOCH_W'(got.retire_advances),
                         EPOCH_W'(want.retire_advances));
      if (word[RSP_W-1:RSP_BITS] !== '0)
         report_mismatch("pad bits", EPOCH_W'(word[RSP_W-1:RSP_BITS]), '0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         check_result(rsp_tdata);
      end
   end

   // Result side: a long hold-off when asked, otherwise a stall pattern that
   // is drawn anew at random (always ready, sparse, regular, heavy)
   initial begin
      int phase;
      int mode;
      phase = 0;
      mode  = 0;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_tready    = 1'b0;
            hold_off_left = hold_off_left - 1;
         end else begin
            phase++;
            if ((phase % 128) == 0) mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = ($urandom_range(0, 99) >= 25);
               2:       rsp_tready = ((phase % 5) < 3);
               default: rsp_tready = ($urandom_range(0, 99) >= 75);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- sending

   // Offer one item from a falling edge, hold it until taken, return on the next falling edge
   task automatic send_item(seat_op_type op, bit [EPOCH_W-1:0] e);
      req_tuser  = op;
      req_tdata  = e;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(track_epoch(op, e));
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid for a while, with junk on the payload
   task automatic idle_gap(int cycles);
      req_tvalid = 1'b0;
      req_tdata  = random_epoch();
      req_tuser  = OP_W'($urandom_range(0, 3));
      repeat (cycles) @(negedge clock);
   endtask

   task automatic paced_send(seat_op_type op, bit [EPOCH_W-1:0] e);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      burst_left--;
      send_item(op, e);
   endtask

   // Hold the input off until every outstanding result has come back
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      send_item(OP_OBSERVE, '0);                 // zero is invalid
      send_item(OP_OBSERVE, 64'd1);              // epoch one: nothing older to retire
      send_item(OP_OBSERVE, 64'd1);              // same candidate again
      send_item(OP_COMMIT,  64'd2);              // commit of the wrong epoch is refused
      send_item(OP_COMMIT,  64'd1);              // promote
      send_item(OP_OBSERVE, 64'd1);              // now active
      send_item(OP_COMMIT,  64'd1);              // refused, no candidate held
      send_item(OP_OBSERVE, 64'd5);
      send_item(OP_OBSERVE, 64'd3);              // below the candidate
      send_item(OP_OBSERVE, 64'd9);              // displaces candidate five
      send_item(OP_OBSERVE, 64'd4);              // at or below the mark
      send_item(OP_REJECT,  64'd7);              // no matching candidate
      send_item(OP_REJECT,  64'd9);              // candidate retired
      send_item(OP_COMMIT,  64'd9);              // retired epoch cannot be promoted
      send_item(OP_OBSERVE, 64'd12);
      send_item(OP_COMMIT,  64'd12);             // old active is below the mark already
      send_item(OP_OBSERVE, 64'd10);             // above the mark but below the active epoch
      send_item(OP_CLEAR,   64'hAAAA_AAAA_AAAA_AAAA);
      send_item(OP_OBSERVE, 64'h5555_5555_5555_5555);
      send_item(OP_OBSERVE, '1);                 // highest epoch displaces the candidate
      send_item(OP_COMMIT,  '1);
      send_item(OP_OBSERVE, '1);
      send_item(OP_OBSERVE, 64'hFFFF_FFFF_FFFF_FFFE);
      send_item(OP_CLEAR,   '1);
      send_item(OP_REJECT,  '0);
      wait_drained();
   endtask

   // Starve the result side so the block fills and pushes back on the input
   task automatic test_long_holdoff();
      bit [EPOCH_W-1:0] e;
      @(posedge clock);
      hold_off_left = RX_HOLD_CYCLES;
      @(negedge clock);
      e = epoch_frontier() + EPOCH_W'(1);
      repeat (12) begin
         send_item(OP_OBSERVE, e);
         send_item(OP_COMMIT, e);
         e = e + $urandom_range(1, 3);
      end
      wait_drained();
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         repeat (30) paced_send(OP_OBSERVE, nearby_epoch());
         wait_drained();
      end
   endtask

   // Mostly well-formed lifecycles with random epochs, the rest noise
   task automatic test_random_traffic(int count);
      bit [EPOCH_W-1:0] e;
      int               first;
      first = items_sent;
      while ((items_sent - first) < count) begin
         if ($urandom_range(0, 9) < 7) begin
            e = fresh_epoch();
            paced_send(OP_OBSERVE, e);
            if ($urandom_range(0, 3) == 0) paced_send(OP_OBSERVE, e);
            if ($urandom_range(0, 3) == 0) begin
               e = fresh_epoch();
               paced_send(OP_OBSERVE, e);
            end
            if ($urandom_range(0, 4) == 0) paced_send(OP_REJECT, e);
            else                           paced_send(OP_COMMIT, e);
            if ($urandom_range(0, 2) == 0) paced_send(OP_OBSERVE, book.active_ep);
         end else if ($urandom_range(0, 14) == 0) begin
            paced_send(OP_CLEAR, random_epoch());
         end else begin
            paced_send(seat_op_type'($urandom_range(0, 2)), nearby_epoch());
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_OBSERVE;
      book       = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_long_holdoff();
      test_drain_pause();
      test_random_traffic(1000);
      wait_drained();

      if (pending_results.size() != 0) begin
         report_mismatch("results never returned", EPOCH_W'(pending_results.size()), '0);
      end
      if (error_count == 0) begin
         $display("** stream_epoch_admission_tracker: PASSED **");
      end else begin
         $display("** stream_epoch_admission_tracker: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** stream_epoch_admission_tracker: FAILED **");
      $finish;
   end

endmodule
